// ===== rtl/core/ckre_pkg.sv =====
// shared types and constants for the color-key run-length sprite encoder
package ckre_pkg;

    // default largest literal span, in pixels
    localparam int MAX_SPAN_DEF = 62;

    // longest skip run carried in one code byte
    localparam logic [6:0] SKIP_LIMIT = 7'h7f;

    // bit 7 of a run code marks a literal span
    localparam logic OP_COPY = 1'b1;
    localparam logic OP_SKIP = 1'b0;

    // byte that closes every scanline
    localparam logic [7:0] EOL_CODE = 8'h00;

    // one input beat
    typedef struct packed {
        logic [7:0] pixel;
        logic       end_of_line;
    } t_in_item;

    // one output beat
    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
    } t_out_item;

endpackage

// ===== rtl/core/ckre_span_mem.sv =====
// span pixel buffer: one write port, one read port with registered data
module ckre_span_mem
    import ckre_pkg::*;
#(
    parameter int DEPTH = MAX_SPAN_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data appears the cycle after the address is presented
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/color_key_rle_sprite_encoder_core.sv =====
// color-key run-length sprite encoder: sequencer, output register and span buffer
// The core takes no new pixel until its sequencer is back in S_IDLE; each buffered
// pixel of a span flush is read, then emitted, through the single read port of the
// span buffer.
// Reset (i_rst_n low, synchronous): color key, counts, state and output valid clear.
module color_key_rle_sprite_encoder_core
    import ckre_pkg::*;
#(
    parameter int MAX_SPAN = MAX_SPAN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // configuration
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    // pixel input
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    // code output
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    localparam int AW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
    localparam int CW = $clog2(MAX_SPAN + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SKIP,
        S_OPQ,
        S_HDR,
        S_RD,
        S_DAT,
        S_KEY
    } t_state;

    // the eol byte is reached from S_KEY or S_DAT via this extra state
    typedef enum logic {
        E_NONE,
        E_PEND
    } t_eol_state;

    t_state        r_state, n_state;
    t_eol_state    r_eol_st, n_eol_st;
    logic [7:0]    r_color_key, n_color_key;
    logic          r_eol, n_eol;
    logic          r_key, n_key;
    logic [CW-1:0] r_span, n_span;
    logic [6:0]    r_skip, n_skip;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          slot_free;
    logic          mem_we;
    logic [7:0]    mem_rdata;
    logic          after_last;

    ckre_span_mem #(
        .DEPTH (MAX_SPAN),
        .AW    (AW)
    ) u_span_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_span[AW-1:0]),
        .i_wdata (i_in.pixel),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    assign slot_free = !r_out_valid || i_out_ready;
    assign mem_we    = (r_state == S_IDLE) && i_in_valid && (i_in.pixel != r_color_key);
    // nothing follows the last span pixel unless a skip overflow or line end comes
    assign after_last = !(r_eol || (r_key && (r_skip == SKIP_LIMIT)));

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_eol_st    = r_eol_st;
        n_color_key = r_color_key;
        n_eol       = r_eol;
        n_key       = r_key;
        n_span      = r_span;
        n_skip      = r_skip;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (i_cfg_valid) begin
            n_color_key = i_cfg_data;
        end

        if (r_eol_st == E_PEND) begin
            // closing zero code of the scanline
            if (slot_free) begin
                n_out_valid = 1'b1;
                n_out       = '{code_byte: EOL_CODE, last: 1'b1};
                n_skip      = '0;
                n_eol_st    = E_NONE;
                n_state     = S_IDLE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        n_eol   = i_in.end_of_line;
                        n_key   = (i_in.pixel == r_color_key);
                        n_state = S_START;
                    end
                end
                S_START: begin
                    if (r_key) begin
                        n_state = (r_span != '0) ? S_HDR : S_KEY;
                    end else begin
                        n_state = (r_skip != '0) ? S_SKIP : S_OPQ;
                    end
                end
                S_SKIP: begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{code_byte: {OP_SKIP, r_skip},
                                        last: (r_span != CW'(MAX_SPAN - 1)) && !r_eol};
                        n_skip      = '0;
                        n_state     = S_OPQ;
                    end
                end
                S_OPQ: begin
                    // pixel was written at accept
                    n_span = r_span + CW'(1);
                    if ((r_span == CW'(MAX_SPAN - 1)) || r_eol) begin
                        n_state = S_HDR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
                S_HDR: begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{code_byte: {OP_COPY, 7'(r_span)}, last: 1'b0};
                        n_idx       = '0;
                        n_state     = S_RD;
                    end
                end
                S_RD: begin
                    n_state = S_DAT;
                end
                S_DAT: begin
                    if (slot_free) begin
                        n_out_valid = 1'b1;
                        if ((CW'(r_idx) + CW'(1)) == r_span) begin
                            n_out  = '{code_byte: mem_rdata, last: after_last};
                            n_span = '0;
                            if (r_key) begin
                                n_state = S_KEY;
                            end else if (r_eol) begin
                                n_eol_st = E_PEND;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_out   = '{code_byte: mem_rdata, last: 1'b0};
                            n_idx   = r_idx + AW'(1);
                            n_state = S_RD;
                        end
                    end
                end
                S_KEY: begin
                    if (r_skip == SKIP_LIMIT) begin
                        // skip overflow, emit a full run and restart at one
                        if (slot_free) begin
                            n_out_valid = 1'b1;
                            n_out       = '{code_byte: {OP_SKIP, SKIP_LIMIT}, last: !r_eol};
                            n_skip      = 7'd1;
                            if (r_eol) begin
                                n_eol_st = E_PEND;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                    end else begin
                        n_skip = r_skip + 7'd1;
                        if (r_eol) begin
                            n_eol_st = E_PEND;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_eol_st    <= E_NONE;
            r_color_key <= '0;
            r_span      <= '0;
            r_skip      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_eol_st    <= n_eol_st;
            r_color_key <= n_color_key;
            r_span      <= n_span;
            r_skip      <= n_skip;
            r_out_valid <= n_out_valid;
        end
        r_eol <= n_eol;
        r_key <= n_key;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && (r_eol_st == E_NONE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/ckre_checker.sv =====
// port-level checks for the encoder core, bound to the encoder core
module ckre_port_props
    import ckre_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    // an accepted pixel drops ready in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after accepting a pixel");

    // a pending non-final beat means more bytes of this pixel are coming
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.last |-> !o_in_ready)
        else $error("ready high while a pixel's output is incomplete");

    // a waiting pixel beat holds until accepted
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("input beat changed while waiting");

endmodule

bind color_key_rle_sprite_encoder_core ckre_port_props u_ckre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
